>>> rtl/ttrg_pkg.sv
// ----------------------------------------------------------------------------
// ttrg_pkg
// Shared widths, payload types and command codes of the tile rectangle
// generator.
// ----------------------------------------------------------------------------
package ttrg_pkg;

  localparam int unsigned COORD_W    = 13;
  localparam int unsigned DCOORD_W   = COORD_W + 1;
  localparam int unsigned PAT_W      = 12;
  localparam int unsigned SCALE_W    = 12;
  localparam int unsigned SFRAC_W    = 8;
  localparam int unsigned SRC_FRAC_W = 8;
  localparam int unsigned SRC_W      = 20;
  localparam int unsigned TPX_W      = 16;
  localparam int unsigned PROD_W     = PAT_W + COORD_W;
  localparam int unsigned DIVN_W     = PROD_W + SRC_FRAC_W;
  localparam int unsigned DIV_STEPS  = SRC_W;
  localparam int unsigned DCNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [PAT_W-1:0]     pat_x;
    logic [PAT_W-1:0]     pat_y;
    logic [PAT_W-1:0]     pat_width;
    logic [PAT_W-1:0]     pat_height;
    logic [COORD_W-1:0]   area_x;
    logic [COORD_W-1:0]   area_y;
    logic [COORD_W-1:0]   area_width;
    logic [COORD_W-1:0]   area_height;
    logic [SCALE_W-1:0]   scale_q8;
    logic                 texture_ok;
  } ttrg_in_t;

  typedef struct packed {
    logic [PAT_W-1:0]     tile_src_x;
    logic [PAT_W-1:0]     tile_src_y;
    logic [SRC_W-1:0]     tile_src_width;
    logic [SRC_W-1:0]     tile_src_height;
    logic [DCOORD_W-1:0]  tile_x;
    logic [DCOORD_W-1:0]  tile_y;
    logic [COORD_W-1:0]   tile_width;
    logic [COORD_W-1:0]   tile_height;
    logic                 last_tile;
    logic                 nothing_drawn;
  } ttrg_out_t;

endpackage

>>> rtl/ttrg_in_if.sv
// ----------------------------------------------------------------------------
// ttrg_in_if
// Request channel of the tile rectangle generator.
// ----------------------------------------------------------------------------
interface ttrg_in_if;
  import ttrg_pkg::*;

  logic     valid;
  logic     ready;
  ttrg_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ttrg_out_if.sv
// ----------------------------------------------------------------------------
// ttrg_out_if
// Result channel of the tile rectangle generator.
// ----------------------------------------------------------------------------
interface ttrg_out_if;
  import ttrg_pkg::*;

  logic      valid;
  logic      ready;
  ttrg_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ttrg_divider.sv
// ----------------------------------------------------------------------------
// ttrg_divider
// Restoring divider, one quotient bit per cycle: ({num, 8'b0}) / den.
// Quotient is known to fit in SRC_W bits.
// ----------------------------------------------------------------------------
module ttrg_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ttrg_pkg::PROD_W-1:0]  num_i,
  input  logic [ttrg_pkg::TPX_W-1:0]   den_i,
  output logic                         done_o,
  output logic [ttrg_pkg::SRC_W-1:0]   quo_o
);
  import ttrg_pkg::*;

  logic [DIVN_W-1:0] dnum;
  logic [TPX_W-1:0]  rem_q;
  logic [SRC_W-1:0]  shf_q;
  logic [SRC_W-1:0]  quo_q;
  logic [TPX_W-1:0]  den_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [TPX_W:0]    trial;
  logic              ge;

  assign dnum  = {num_i, {SRC_FRAC_W{1'b0}}};
  assign trial = {rem_q, shf_q[SRC_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      shf_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= TPX_W'(dnum[DIVN_W-1:SRC_W]);
        shf_q  <= dnum[SRC_W-1:0];
        den_q  <= den_i;
        quo_q  <= '0;
        cnt_q  <= DCNT_W'(DIV_STEPS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? TPX_W'(trial - {1'b0, den_q}) : TPX_W'(trial);
        shf_q <= {shf_q[SRC_W-2:0], 1'b0};
        quo_q <= {quo_q[SRC_W-2:0], ge};
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/texture_tile_rect_generator_top.sv
// ----------------------------------------------------------------------------
// texture_tile_rect_generator_top
// Splits a destination area into tiles of the scaled pattern size, column by
// column, and returns one source/destination rectangle pair per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries requests. A start request loads the pattern, area, scale
//   and texture flag and returns the first tile; a next request returns the
//   following tile of the running job. rsp_o returns exactly one result per
//   request; nothing_drawn marks an invalid start or a next request with no
//   running job, and last_tile marks the final tile of a job.
//   One request is in work at a time; req_i.ready is high only when idle.
//   A start request first forms the tile width and height and checks the
//   job before it clips like a next request. Each clipped axis adds one
//   run of the 20-step serial divider. The shared 12x13 multiplier forms
//   the tile sizes and the clipped source products one after another.
//   The result sits in an output register; a new request is taken while it
//   waits, but the next result waits until the receiver takes the old one.
//   Reset clears the running job and empties the output register.
// ----------------------------------------------------------------------------
module texture_tile_rect_generator_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  ttrg_in_if.sink    req_i,
  ttrg_out_if.source rsp_o
);
  import ttrg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TILE_W,
    S_TILE_H,
    S_CHECK,
    S_CLIP,
    S_DIV_GO,
    S_DIV,
    S_OUT
  } state_e;

  state_e             state_q;
  logic               axis_q;
  logic               job_active_q;
  logic               nothing_q;
  logic               tex_q;
  logic [SCALE_W-1:0] scale_q;
  logic [PAT_W-1:0]   pat_x_q, pat_y_q, pat_w_q, pat_h_q;
  logic [COORD_W-1:0] area_x_q, area_y_q, area_w_q, area_h_q;
  logic [TPX_W-1:0]   tile_w_q, tile_h_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic [SRC_W-1:0]   sw_q, sh_q;
  logic [COORD_W-1:0] dw_q, dh_q;
  logic [PROD_W-1:0]  prod_q;
  logic               out_valid_q;
  ttrg_out_t          out_q;

  logic [PAT_W-1:0]   mul_a;
  logic [COORD_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [COORD_W-1:0] rem;
  logic [TPX_W-1:0]   tile_cur;
  logic [PAT_W-1:0]   pat_cur;
  logic               full;
  logic               invalid;
  logic [TPX_W:0]     next_row, next_col;
  logic               row_end, col_end, last;
  logic               out_free;
  logic               div_start, div_done;
  logic [SRC_W-1:0]   div_quo;
  ttrg_out_t          res;

  assign rem      = axis_q ? (area_h_q - row_q) : (area_w_q - col_q);
  assign tile_cur = axis_q ? tile_h_q : tile_w_q;
  assign pat_cur  = axis_q ? pat_h_q : pat_w_q;
  assign full     = TPX_W'(rem) >= tile_cur;

  always_comb begin
    case (state_q)
      S_TILE_W: begin
        mul_a = pat_w_q;
        mul_b = COORD_W'(scale_q);
      end
      S_TILE_H: begin
        mul_a = pat_h_q;
        mul_b = COORD_W'(scale_q);
      end
      default: begin
        mul_a = pat_cur;
        mul_b = rem;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign invalid = !tex_q || (scale_q == '0) || (pat_w_q == '0) || (pat_h_q == '0) ||
                   (area_w_q == '0) || (area_h_q == '0) ||
                   (tile_w_q == '0) || (tile_h_q == '0);

  assign next_row = (TPX_W+1)'(row_q) + (TPX_W+1)'(tile_h_q);
  assign next_col = (TPX_W+1)'(col_q) + (TPX_W+1)'(tile_w_q);
  assign row_end  = next_row >= (TPX_W+1)'(area_h_q);
  assign col_end  = next_col >= (TPX_W+1)'(area_w_q);
  assign last     = row_end && col_end;

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign div_start = (state_q == S_DIV_GO);

  always_comb begin
    res = '0;
    if (nothing_q) begin
      res.nothing_drawn = 1'b1;
    end else begin
      res.tile_src_x      = pat_x_q;
      res.tile_src_y      = pat_y_q;
      res.tile_src_width  = sw_q;
      res.tile_src_height = sh_q;
      res.tile_x          = DCOORD_W'(area_x_q) + DCOORD_W'(col_q);
      res.tile_y          = DCOORD_W'(area_y_q) + DCOORD_W'(row_q);
      res.tile_width      = dw_q;
      res.tile_height     = dh_q;
      res.last_tile       = last;
    end
  end

  ttrg_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (tile_cur),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      axis_q       <= 1'b0;
      job_active_q <= 1'b0;
      nothing_q    <= 1'b0;
      tex_q        <= 1'b0;
      scale_q      <= '0;
      pat_x_q      <= '0;
      pat_y_q      <= '0;
      pat_w_q      <= '0;
      pat_h_q      <= '0;
      area_x_q     <= '0;
      area_y_q     <= '0;
      area_w_q     <= '0;
      area_h_q     <= '0;
      tile_w_q     <= '0;
      tile_h_q     <= '0;
      col_q        <= '0;
      row_q        <= '0;
      sw_q         <= '0;
      sh_q         <= '0;
      dw_q         <= '0;
      dh_q         <= '0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            axis_q    <= 1'b0;
            nothing_q <= 1'b0;
            if (req_i.data.command == CMD_START) begin
              tex_q    <= req_i.data.texture_ok;
              scale_q  <= req_i.data.scale_q8;
              pat_x_q  <= req_i.data.pat_x;
              pat_y_q  <= req_i.data.pat_y;
              pat_w_q  <= req_i.data.pat_width;
              pat_h_q  <= req_i.data.pat_height;
              area_x_q <= req_i.data.area_x;
              area_y_q <= req_i.data.area_y;
              area_w_q <= req_i.data.area_width;
              area_h_q <= req_i.data.area_height;
              state_q  <= S_TILE_W;
            end else if (job_active_q) begin
              state_q <= S_CLIP;
            end else begin
              nothing_q <= 1'b1;
              state_q   <= S_OUT;
            end
          end
        end
        S_TILE_W: begin
          tile_w_q <= mul_p[SFRAC_W +: TPX_W];
          state_q  <= S_TILE_H;
        end
        S_TILE_H: begin
          tile_h_q <= mul_p[SFRAC_W +: TPX_W];
          state_q  <= S_CHECK;
        end
        S_CHECK: begin
          col_q <= '0;
          row_q <= '0;
          if (invalid) begin
            job_active_q <= 1'b0;
            nothing_q    <= 1'b1;
            state_q      <= S_OUT;
          end else begin
            job_active_q <= 1'b1;
            state_q      <= S_CLIP;
          end
        end
        S_CLIP: begin
          prod_q <= mul_p;
          if (full) begin
            if (axis_q) begin
              sh_q    <= {pat_h_q, {SRC_FRAC_W{1'b0}}};
              dh_q    <= tile_h_q[COORD_W-1:0];
              state_q <= S_OUT;
            end else begin
              sw_q   <= {pat_w_q, {SRC_FRAC_W{1'b0}}};
              dw_q   <= tile_w_q[COORD_W-1:0];
              axis_q <= 1'b1;
            end
          end else begin
            if (axis_q) begin
              dh_q <= rem;
            end else begin
              dw_q <= rem;
            end
            state_q <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (axis_q) begin
              sh_q    <= div_quo;
              state_q <= S_OUT;
            end else begin
              sw_q    <= div_quo;
              axis_q  <= 1'b1;
              state_q <= S_CLIP;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (!nothing_q) begin
              if (last) begin
                job_active_q <= 1'b0;
                col_q        <= '0;
                row_q        <= '0;
              end else if (row_end) begin
                row_q <= '0;
                col_q <= next_col[COORD_W-1:0];
              end else begin
                row_q <= next_row[COORD_W-1:0];
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

>>> rtl/ttrg_checker.sv
// ----------------------------------------------------------------------------
// ttrg_checker
// Port-level checks of the tile rectangle generator, bound to the top level.
// ----------------------------------------------------------------------------
module ttrg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ttrg_pkg::ttrg_out_t out_data_i
);
  import ttrg_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // one request in work at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  a_nothing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.nothing_drawn |->
      out_data_i.tile_width == '0 && out_data_i.tile_height == '0 &&
      out_data_i.tile_src_width == '0 && out_data_i.tile_src_height == '0 &&
      out_data_i.tile_x == '0 && out_data_i.tile_y == '0 && !out_data_i.last_tile)
    else $error("nothing_drawn result carries data");

  a_tile_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.nothing_drawn |->
      out_data_i.tile_width != '0 && out_data_i.tile_height != '0)
    else $error("empty tile emitted");

endmodule

bind texture_tile_rect_generator_top ttrg_checker u_ttrg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_data_i  (rsp_o.data)
);

>>> verif/ttrg_tile_checker.sv
// ----------------------------------------------------------------------------
// ttrg_tile_checker
// Watches the request and result channels of the tile rectangle generator.
// Each accepted request is run through a local model of the tiling walk.
// The model keeps its own copy of the job, the tile size and the offsets.
// Each accepted result is compared field by field with the oldest predicted
// tile. The mismatch count and the number of tiles still owed go to the
// test top.
// ----------------------------------------------------------------------------
module ttrg_tile_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttrg_in_if          req_mon,
  ttrg_out_if         rsp_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned tiles_owed_o
);
  import ttrg_pkg::*;

  logic                job_live = 1'b0;
  logic [PAT_W-1:0]    jp_x = '0, jp_y = '0, jp_w = '0, jp_h = '0;
  logic [COORD_W-1:0]  ja_x = '0, ja_y = '0, ja_w = '0, ja_h = '0;
  logic [TPX_W-1:0]    tw = '0, th = '0;
  logic [COORD_W-1:0]  col_off = '0, row_off = '0;

  ttrg_out_t   owed_tiles[$];
  int unsigned mismatches = 0;
  int unsigned owed_n     = 0;

  assign mismatch_cnt_o = mismatches;
  assign tiles_owed_o   = owed_n;

  task automatic clip_extent(input logic [63:0] pat, tile, span, off,
                             output logic [63:0] src, dst);
    logic [63:0] rem;
    rem = span - off;
    if (rem >= tile) begin
      src = (pat << SRC_FRAC_W) & 64'hFFFFF;
      dst = tile;
    end else begin
      src = ((pat * rem) << SRC_FRAC_W) / tile;
      dst = rem;
    end
  endtask

  task automatic advance_job(input ttrg_in_t r, output ttrg_out_t t);
    logic [63:0] pw, ph, aw, ah, sc, nw, nh;
    logic [63:0] sw, sh, dw, dh, next_row, next_col, tx, ty;
    logic        fin;
    t = '0;
    if (r.command == CMD_START) begin
      pw = 64'(r.pat_width);
      ph = 64'(r.pat_height);
      aw = 64'(r.area_width);
      ah = 64'(r.area_height);
      sc = 64'(r.scale_q8);
      nw = ((pw * sc) >> SFRAC_W) & 64'hFFFF;
      nh = ((ph * sc) >> SFRAC_W) & 64'hFFFF;
      job_live = 1'b0;
      if (!r.texture_ok || sc == 0 || pw == 0 || ph == 0 || aw == 0 || ah == 0 ||
          nw == 0 || nh == 0) begin
        t.nothing_drawn = 1'b1;
        return;
      end
      job_live = 1'b1;
      jp_x     = r.pat_x;
      jp_y     = r.pat_y;
      jp_w     = r.pat_width;
      jp_h     = r.pat_height;
      ja_x     = r.area_x;
      ja_y     = r.area_y;
      ja_w     = r.area_width;
      ja_h     = r.area_height;
      tw       = nw[TPX_W-1:0];
      th       = nh[TPX_W-1:0];
      col_off  = '0;
      row_off  = '0;
    end else if (!job_live) begin
      t.nothing_drawn = 1'b1;
      return;
    end

    clip_extent(64'(jp_w), 64'(tw), 64'(ja_w), 64'(col_off), sw, dw);
    clip_extent(64'(jp_h), 64'(th), 64'(ja_h), 64'(row_off), sh, dh);
    next_row = 64'(row_off) + 64'(th);
    next_col = 64'(col_off) + 64'(tw);
    fin      = (next_row >= 64'(ja_h)) && (next_col >= 64'(ja_w));
    tx       = 64'(ja_x) + 64'(col_off);
    ty       = 64'(ja_y) + 64'(row_off);

    t.tile_src_x      = jp_x;
    t.tile_src_y      = jp_y;
    t.tile_src_width  = sw[SRC_W-1:0];
    t.tile_src_height = sh[SRC_W-1:0];
    t.tile_x          = tx[DCOORD_W-1:0];
    t.tile_y          = ty[DCOORD_W-1:0];
    t.tile_width      = dw[COORD_W-1:0];
    t.tile_height     = dh[COORD_W-1:0];
    t.last_tile       = fin;

    if (fin) begin
      job_live = 1'b0;
      col_off  = '0;
      row_off  = '0;
    end else if (next_row >= 64'(ja_h)) begin
      row_off = '0;
      col_off = next_col[COORD_W-1:0];
    end else begin
      row_off = next_row[COORD_W-1:0];
    end
  endtask

  function automatic string diff_field(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return "";
    return $sformatf(" %s exp %0h got %0h;", name, want, got);
  endfunction

  always @(posedge clk_i) begin : watch
    ttrg_out_t want, got;
    string     bad;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) begin
        advance_job(req_mon.data, want);
        owed_tiles.push_back(want);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (owed_tiles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tile checker: result with no request pending: %h", got);
        end else begin
          want = owed_tiles.pop_front();
          bad = {diff_field("src_x", 32'(want.tile_src_x), 32'(got.tile_src_x)),
                 diff_field("src_y", 32'(want.tile_src_y), 32'(got.tile_src_y)),
                 diff_field("src_w", 32'(want.tile_src_width), 32'(got.tile_src_width)),
                 diff_field("src_h", 32'(want.tile_src_height),
                            32'(got.tile_src_height)),
                 diff_field("x", 32'(want.tile_x), 32'(got.tile_x)),
                 diff_field("y", 32'(want.tile_y), 32'(got.tile_y)),
                 diff_field("w", 32'(want.tile_width), 32'(got.tile_width)),
                 diff_field("h", 32'(want.tile_height), 32'(got.tile_height)),
                 diff_field("last", 32'(want.last_tile), 32'(got.last_tile)),
                 diff_field("none", 32'(want.nothing_drawn), 32'(got.nothing_drawn))};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= 10)
              $display("tile checker: mismatch:%s", bad);
          end
        end
      end
      owed_n = owed_tiles.size();
    end
  end

endmodule

>>> verif/texture_tile_rect_generator_top_test.sv
// ----------------------------------------------------------------------------
// texture_tile_rect_generator_top_test
// Drives start and next requests into the tile rectangle generator. A short
// directed part covers the field extremes, most invalid starts, next with no
// job, restart and job end. Random tiling jobs with a few tiles each follow,
// mixed with noise requests. Both channels idle at random. The checker beside
// the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module texture_tile_rect_generator_top_test;
  import ttrg_pkg::*;

  localparam int unsigned N_REQS      = 2000;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned DRAIN_WAIT  = 80;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic calm   = 1'b0;

  int unsigned sent   = 0;
  int unsigned cycles = 0;
  int unsigned mismatches;
  int unsigned tiles_owed;

  ttrg_in_if  req_if ();
  ttrg_out_if rsp_if ();

  texture_tile_rect_generator_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ttrg_tile_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .rsp_mon        (rsp_if),
    .mismatch_cnt_o (mismatches),
    .tiles_owed_o   (tiles_owed)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("texture_tile_rect_generator_top regression: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= calm || ($urandom_range(0, 99) >= 18);
  end

  function automatic ttrg_in_t make_req(logic cmd, int unsigned px, py, pw, ph,
                                        int unsigned ax, ay, aw, ah, sc, logic ok);
    ttrg_in_t r;
    r.command     = cmd;
    r.pat_x       = px[PAT_W-1:0];
    r.pat_y       = py[PAT_W-1:0];
    r.pat_width   = pw[PAT_W-1:0];
    r.pat_height  = ph[PAT_W-1:0];
    r.area_x      = ax[COORD_W-1:0];
    r.area_y      = ay[COORD_W-1:0];
    r.area_width  = aw[COORD_W-1:0];
    r.area_height = ah[COORD_W-1:0];
    r.scale_q8    = sc[SCALE_W-1:0];
    r.texture_ok  = ok;
    return r;
  endfunction

  function automatic ttrg_in_t rand_req(logic cmd);
    return make_req(cmd, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 8191), $urandom_range(0, 8191),
                    $urandom_range(0, 8191), $urandom_range(0, 8191),
                    $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
  endfunction

  // entered and left at a falling edge
  task automatic push_req(input ttrg_in_t r);
    while (!calm && $urandom_range(0, 99) < 18) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
    calm = (sent >= 700) && (sent < 1000);
    @(negedge clk_i);
  endtask

  task automatic push_nexts(input int unsigned n);
    repeat (n) push_req(rand_req(CMD_NEXT));
  endtask

  function automatic int unsigned pick_span(int unsigned t);
    int unsigned n, span;
    n = $urandom_range(1, 4);
    if (t >= 8191) return $urandom_range(1, 8191);
    if ($urandom_range(0, 3) == 0) span = t * n;
    else span = t * (n - 1) + $urandom_range(1, t);
    if (span > 8191) span = 8191;
    return span;
  endfunction

  task automatic run_job();
    int unsigned pw, ph, sc, tw, th, aw, ah, tiles, pick;
    do begin
      pw = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 64) : $urandom_range(1, 4095);
      ph = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 64) : $urandom_range(1, 4095);
      sc = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 512) : $urandom_range(1, 4095);
      tw = (pw * sc) >> SFRAC_W;
      th = (ph * sc) >> SFRAC_W;
    end while (tw == 0 || th == 0);
    aw    = pick_span(tw);
    ah    = pick_span(th);
    tiles = ((aw + tw - 1) / tw) * ((ah + th - 1) / th);
    push_req(make_req(CMD_START, $urandom_range(0, 4095), $urandom_range(0, 4095), pw, ph,
                      $urandom_range(0, 8191), $urandom_range(0, 8191), aw, ah, sc, 1'b1));
    pick = $urandom_range(0, 99);
    if (pick < 80)      push_nexts(tiles - 1);
    else if (pick < 90) push_nexts($urandom_range(0, tiles - 1));
    else                push_nexts(tiles - 1 + $urandom_range(1, 2));
  endtask

  initial begin
    int unsigned pick;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    push_req(rand_req(CMD_NEXT));
    push_req(make_req(CMD_START, 4095, 4095, 4095, 4095, 8191, 8191, 8191, 8191, 4095, 1'b1));
    push_req(rand_req(CMD_NEXT));
    push_req(make_req(CMD_START, 1, 2, 16, 8, 10, 20, 32, 16, 256, 1'b0));
    push_req(make_req(CMD_START, 1, 2, 16, 8, 10, 20, 32, 16, 0, 1'b1));
    push_req(make_req(CMD_START, 1, 2, 0, 8, 10, 20, 32, 16, 256, 1'b1));
    push_req(make_req(CMD_START, 1, 2, 16, 0, 10, 20, 32, 16, 256, 1'b1));
    push_req(make_req(CMD_START, 1, 2, 16, 8, 10, 20, 0, 16, 256, 1'b1));
    push_req(make_req(CMD_START, 1, 2, 16, 8, 10, 20, 32, 0, 256, 1'b1));
    push_req(make_req(CMD_START, 1, 2, 1, 8, 10, 20, 32, 16, 255, 1'b1));
    // full tiles only, 2 x 2
    push_req(make_req(CMD_START, 0, 0, 16, 8, 0, 0, 32, 16, 256, 1'b1));
    push_nexts(3);
    // clipped column and row, abandoned midway
    push_req(make_req(CMD_START, 7, 9, 10, 10, 100, 200, 40, 20, 384, 1'b1));
    push_nexts(2);
    // restart: wide tiles across the full area width
    push_req(make_req(CMD_START, 3, 5, 4095, 1, 0, 8191, 8191, 2, 256, 1'b1));
    push_nexts(6);

    while (sent < N_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85)      run_job();
      else if (pick < 93) push_req(rand_req(1'($urandom_range(0, 1))));
      else                push_req(rand_req(CMD_START));
    end
    req_if.valid <= 1'b0;

    while (tiles_owed != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && tiles_owed == 0) begin
      $display("texture_tile_rect_generator_top regression: pass");
    end else begin
      $display("texture_tile_rect_generator_top regression: fail");
    end
    $finish;
  end

endmodule
